// ===== rtl/tpp_pkg.sv =====
// Shared constants and types of the packet template parser.
package tpp_pkg;

    localparam int MAX_SEGMENTS  = 16;
    localparam int STATIC_BYTES  = 1024;
    localparam int TOTAL_CAP     = 2047;
    localparam int NUM_LIMIT     = 100000;
    localparam int MAX_TOTAL_RST = 1500;

    // Result queue depth; an input word may push two results at once.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        KIND_STATIC    = 3'd0,
        KIND_RANDOM    = 3'd1,
        KIND_LETTERS   = 3'd2,
        KIND_DIGITS    = 3'd3,
        KIND_TIMESTAMP = 3'd4,
        KIND_COUNTER   = 3'd5
    } t_kind;

    typedef struct packed {
        logic        seg_valid;
        t_kind       seg_kind;
        logic [19:0] seg_length;
        logic [9:0]  seg_offset;
        logic        done_res;
        logic        status;
        logic [4:0]  segment_count;
        logic [10:0] total_size;
        logic        end_of_run;
    } t_result;

    typedef struct packed {
        logic seg_v;
        logic sum_v;
    } t_push;

endpackage

// ===== rtl/tpp_if.sv =====
// Handshake channels of the packet template parser.
interface tpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface tpp_out_if;
    logic        valid;
    logic        ready;
    logic        seg_valid;
    logic [2:0]  seg_kind;
    logic [19:0] seg_length;
    logic [9:0]  seg_offset;
    logic        done_res;
    logic        status;
    logic [4:0]  segment_count;
    logic [10:0] total_size;
    logic        end_of_run;

    modport source (output valid, output seg_valid, output seg_kind, output seg_length,
                    output seg_offset, output done_res, output status,
                    output segment_count, output total_size, output end_of_run,
                    input ready);
    modport sink (input valid, input seg_valid, input seg_kind, input seg_length,
                  input seg_offset, input done_res, input status,
                  input segment_count, input total_size, input end_of_run,
                  output ready);
endinterface

interface tpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] max_total;

    modport source (output valid, output max_total, input ready);
    modport sink (input valid, input max_total, output ready);
endinterface

// ===== rtl/tpp_parser.sv =====
// Character-level template parser: state registers and result generation.
module tpp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    input  logic             i_cfg_we,
    input  logic [10:0]      i_cfg_data,
    output tpp_pkg::t_push   o_push,
    output tpp_pkg::t_result o_seg,
    output tpp_pkg::t_result o_sum
);
    import tpp_pkg::*;

    typedef enum logic [3:0] {
        PH_OUT  = 4'd0,
        PH_KIND = 4'd1,
        PH_BSP  = 4'd2,
        PH_BX   = 4'd3,
        PH_BHEX = 4'd4,
        PH_RSEL = 4'd5,
        PH_RNUM = 4'd6,
        PH_SKIP = 4'd7,
        PH_ERR  = 4'd8
    } t_phase;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_UX  = 8'h58;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_D   = 8'h64;
    localparam logic [7:0] CH_LF_ = 8'h66;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_LX  = 8'h78;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [19:0] r_num, n_num;
    logic        r_digit, n_digit;
    logic        r_half, n_half;
    logic [10:0] r_tag_bytes, n_tag_bytes;
    logic [4:0]  r_seg_total, n_seg_total;
    logic [10:0] r_bytes_used, n_bytes_used;
    logic [10:0] r_size_sum, n_size_sum;
    logic [10:0] r_max_total;

    logic        ws, dig, hex, closed, bad;
    logic [19:0] clen, num_x10, dval;
    logic [20:0] sum_wide;

    assign ws  = (i_ch == CH_SP) || (i_ch == CH_TAB);
    assign dig = (i_ch >= CH_0) && (i_ch <= CH_9);
    assign hex = dig || ((i_ch >= CH_LA) && (i_ch <= CH_LF_))
                     || ((i_ch >= CH_UA) && (i_ch <= CH_UF));
    assign dval    = 20'(i_ch - CH_0);
    assign num_x10 = (r_num << 3) + (r_num << 1);

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_num        = r_num;
        n_digit      = r_digit;
        n_half       = r_half;
        n_tag_bytes  = r_tag_bytes;
        n_seg_total  = r_seg_total;
        n_bytes_used = r_bytes_used;
        n_size_sum   = r_size_sum;
        closed       = 1'b0;
        clen         = '0;
        sum_wide     = '0;
        bad          = 1'b0;
        o_seg        = '0;
        o_sum        = '0;

        if (i_acc && (i_ch != CH_NUL)) begin
            unique case (r_phase)
                PH_OUT: begin
                    if (ws || (i_ch == CH_LF) || (i_ch == CH_CR)) begin
                    end else if ((i_ch != CH_LT) || (r_seg_total >= 5'(MAX_SEGMENTS))) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_phase     = PH_KIND;
                        n_kind      = KIND_STATIC;
                        n_num       = '0;
                        n_digit     = 1'b0;
                        n_half      = 1'b0;
                        n_tag_bytes = '0;
                    end
                end
                PH_KIND: begin
                    priority if (i_ch == CH_B) begin
                        n_kind  = KIND_STATIC;
                        n_phase = PH_BSP;
                    end else if (i_ch == CH_R) begin
                        n_phase = PH_RSEL;
                    end else if (i_ch == CH_T) begin
                        n_kind  = KIND_TIMESTAMP;
                        n_phase = PH_SKIP;
                    end else if (i_ch == CH_C) begin
                        n_kind  = KIND_COUNTER;
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_BSP: begin
                    if (ws) begin
                    end else if (i_ch == CH_0) begin
                        n_phase = PH_BX;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_BX: begin
                    n_phase = ((i_ch == CH_LX) || (i_ch == CH_UX)) ? PH_BHEX : PH_ERR;
                end
                PH_BHEX: begin
                    priority if (i_ch == CH_GT) begin
                        if (!r_half && (r_tag_bytes != '0)) begin
                            closed = 1'b1;
                            clen   = 20'(r_tag_bytes);
                        end else begin
                            n_phase = PH_ERR;
                        end
                    end else if (!hex) begin
                        n_phase = PH_ERR;
                    end else if (!r_half) begin
                        n_half = 1'b1;
                    end else if (r_bytes_used >= 11'(STATIC_BYTES)) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_bytes_used = r_bytes_used + 11'd1;
                        n_tag_bytes  = r_tag_bytes + 11'd1;
                        n_half       = 1'b0;
                    end
                end
                PH_RSEL: begin
                    priority if (i_ch == CH_C) begin
                        n_kind  = KIND_LETTERS;
                        n_phase = PH_RNUM;
                    end else if (i_ch == CH_D) begin
                        n_kind  = KIND_DIGITS;
                        n_phase = PH_RNUM;
                    end else if (ws) begin
                        n_kind  = KIND_RANDOM;
                        n_phase = PH_RNUM;
                    end else if (dig) begin
                        n_kind  = KIND_RANDOM;
                        n_phase = PH_RNUM;
                        n_num   = dval;
                        n_digit = 1'b1;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_RNUM: begin
                    priority if (ws) begin
                        if (r_digit) n_phase = PH_ERR;
                    end else if (dig) begin
                        if (r_num > 20'(NUM_LIMIT)) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_num   = num_x10 + dval;
                            n_digit = 1'b1;
                        end
                    end else if (i_ch == CH_GT) begin
                        if (r_digit && (r_num != '0)) begin
                            closed = 1'b1;
                            clen   = r_num;
                        end else begin
                            n_phase = PH_ERR;
                        end
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_SKIP: begin
                    if (i_ch == CH_GT) begin
                        closed = 1'b1;
                        clen   = 20'd4;
                    end
                end
                PH_ERR: begin
                end
                default: begin
                end
            endcase
        end

        if (closed) begin
            n_seg_total = r_seg_total + 5'd1;
            sum_wide    = 21'(r_size_sum) + 21'(clen);
            n_size_sum  = (sum_wide > 21'(TOTAL_CAP)) ? 11'(TOTAL_CAP) : sum_wide[10:0];
            n_phase     = PH_OUT;
            o_seg.seg_valid  = 1'b1;
            o_seg.seg_kind   = r_kind;
            o_seg.seg_length = clen;
            o_seg.seg_offset = (r_kind == KIND_STATIC) ? 10'(r_bytes_used - r_tag_bytes) : '0;
            o_seg.end_of_run = !i_last;
        end

        if (i_acc && i_last) begin
            bad = (n_phase != PH_OUT) || (n_seg_total == '0) || (n_size_sum > r_max_total);
            o_sum.done_res      = 1'b1;
            o_sum.status        = bad;
            o_sum.segment_count = n_seg_total;
            o_sum.total_size    = n_size_sum;
            o_sum.end_of_run    = 1'b1;
            // The next template starts from a clean state.
            n_phase      = PH_OUT;
            n_kind       = KIND_STATIC;
            n_num        = '0;
            n_digit      = 1'b0;
            n_half       = 1'b0;
            n_tag_bytes  = '0;
            n_seg_total  = '0;
            n_bytes_used = '0;
            n_size_sum   = '0;
        end

        o_push.seg_v = closed;
        o_push.sum_v = i_acc && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OUT;
            r_kind       <= KIND_STATIC;
            r_num        <= '0;
            r_digit      <= 1'b0;
            r_half       <= 1'b0;
            r_tag_bytes  <= '0;
            r_seg_total  <= '0;
            r_bytes_used <= '0;
            r_size_sum   <= '0;
            r_max_total  <= 11'(MAX_TOTAL_RST);
        end else begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_num        <= n_num;
            r_digit      <= n_digit;
            r_half       <= n_half;
            r_tag_bytes  <= n_tag_bytes;
            r_seg_total  <= n_seg_total;
            r_bytes_used <= n_bytes_used;
            r_size_sum   <= n_size_sum;
            if (i_cfg_we) r_max_total <= i_cfg_data;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_last) |=> (r_phase == PH_OUT) && (r_seg_total == '0) && (r_size_sum == '0))
        else $error("template state not cleared after final word");

    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_total <= 5'(MAX_SEGMENTS))
        else $error("segment count beyond limit");

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_used <= 11'(STATIC_BYTES)) && (r_tag_bytes <= r_bytes_used))
        else $error("static byte counters inconsistent");

    a_close_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.seg_v |=> (r_phase == PH_OUT))
        else $error("closed tag did not return to outside phase");

endmodule

// ===== rtl/tpp_outq.sv =====
// Small result queue that decouples the parser from the output channel.
module tpp_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpp_pkg::t_push   i_push,
    input  tpp_pkg::t_result i_seg,
    input  tpp_pkg::t_result i_sum,
    output logic             o_space,
    tpp_out_if.source        o_out
);
    import tpp_pkg::*;

    t_result        r_mem [QDEPTH];
    logic [QPW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QPW:0]   r_count, n_count;
    logic [QPW:0]   npush;
    logic           pop;
    logic [QPW-1:0] sum_addr;
    t_result        head;

    assign head    = r_mem[r_rd];
    assign pop     = o_out.valid && o_out.ready;
    assign npush   = (QPW+1)'(i_push.seg_v) + (QPW+1)'(i_push.sum_v);
    // Room for the worst case of two results from the next word.
    assign o_space = r_count <= (QPW+1)'(QDEPTH - 2);
    assign sum_addr = i_push.seg_v ? r_wr + 1'b1 : r_wr;

    assign n_wr    = r_wr + npush[QPW-1:0];
    assign n_rd    = pop ? r_rd + 1'b1 : r_rd;
    assign n_count = r_count + npush - (QPW+1)'(pop);

    assign o_out.valid         = r_count != '0;
    assign o_out.seg_valid     = head.seg_valid;
    assign o_out.seg_kind      = head.seg_kind;
    assign o_out.seg_length    = head.seg_length;
    assign o_out.seg_offset    = head.seg_offset;
    assign o_out.done_res      = head.done_res;
    assign o_out.status        = head.status;
    assign o_out.segment_count = head.segment_count;
    assign o_out.total_size    = head.total_size;
    assign o_out.end_of_run    = head.end_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.seg_v) r_mem[r_wr] <= i_seg;
        if (i_push.sum_v) r_mem[sum_addr] <= i_sum;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + npush) <= (QPW+1)'(QDEPTH))
        else $error("result queue overflow");

    // The pointer difference wraps at the pointer width; a full queue has equal pointers.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[QPW-1:0] == QPW'(r_wr - r_rd)) && (r_count <= (QPW+1)'(QDEPTH)))
        else $error("queue count disagrees with pointers");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !(|npush) && r_count == (QPW+1)'(1)) |=> !o_out.valid)
        else $error("queue not empty after last word taken");

endmodule

// ===== rtl/packet_template_parser.sv =====
// Top level of the packet template parser.
// A result word is written into the result queue when the character that causes it is accepted.
// Throughput: one character per cycle while the result queue has room; the output
// channel moves one word per cycle, so a final character that closes a tag pushes two
// words at once, absorbed by the four-entry result queue.
// Reset: synchronous, active low; clears parser state and queue, max_total returns to 1500.
module packet_template_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpp_in_if.sink    i_in,
    tpp_cfg_if.sink   i_cfg,
    tpp_out_if.source o_out
);
    import tpp_pkg::*;

    t_push   push;
    t_result seg_res, sum_res;
    logic    space;
    logic    acc;

    assign i_in.ready  = space;
    assign i_cfg.ready = 1'b1;
    assign acc         = i_in.valid && i_in.ready;

    tpp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_ch       (i_in.ch),
        .i_last     (i_in.last),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.max_total),
        .o_push     (push),
        .o_seg      (seg_res),
        .o_sum      (sum_res)
    );

    tpp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (seg_res),
        .i_sum   (sum_res),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

// ===== verif/template_checker.sv =====
// Watches the parser channels, predicts every result word and compares it with the block's output.
module template_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tpp_in_if    i_in,
    tpp_cfg_if   i_cfg,
    tpp_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tpp_pkg::*;

    typedef enum logic [3:0] {
        AT_GAP,
        AT_KIND,
        AT_B_BLANK,
        AT_B_X,
        AT_B_HEX,
        AT_R_SELECT,
        AT_R_NUMBER,
        AT_SKIP,
        AT_FAULT
    } t_parse_phase;

    localparam logic [7:0] CH_NONE = 8'h00;
    localparam logic [7:0] CH_SP   = " ";
    localparam logic [7:0] CH_TAB  = "\t";
    localparam logic [7:0] CH_LF   = "\n";
    localparam logic [7:0] CH_CR   = "\r";
    localparam logic [7:0] CH_LT   = "<";
    localparam logic [7:0] CH_GT   = ">";
    localparam logic [7:0] CH_0    = "0";
    localparam logic [7:0] CH_9    = "9";
    localparam logic [7:0] CH_LO_A = "a";
    localparam logic [7:0] CH_LO_F = "f";
    localparam logic [7:0] CH_UP_A = "A";
    localparam logic [7:0] CH_UP_F = "F";
    localparam logic [7:0] CH_B    = "b";
    localparam logic [7:0] CH_R    = "r";
    localparam logic [7:0] CH_T    = "t";
    localparam logic [7:0] CH_C    = "c";
    localparam logic [7:0] CH_D    = "d";
    localparam logic [7:0] CH_LO_X = "x";
    localparam logic [7:0] CH_UP_X = "X";

    localparam logic [19:0] STAMP_BYTES = 20'd4;
    localparam int          SHOWN_FAILS = 10;

    t_parse_phase phase;
    t_kind        tag_kind;
    logic [19:0]  number_value;
    logic         digit_seen;
    logic         nibble_half;
    logic [10:0]  tag_bytes;
    logic [10:0]  bytes_used;
    logic [10:0]  size_sum;
    logic [4:0]   seg_count;
    logic         error_flag;
    logic [10:0]  max_total;

    t_result      awaited_words[$];
    int           fails = 0;

    function automatic void clear_template();
        phase        = AT_GAP;
        tag_kind     = KIND_STATIC;
        number_value = '0;
        digit_seen   = 1'b0;
        nibble_half  = 1'b0;
        tag_bytes    = '0;
        bytes_used   = '0;
        size_sum     = '0;
        seg_count    = '0;
        error_flag   = 1'b0;
    endfunction

    // Once in fault, everything up to the final word of the template is ignored.
    function automatic void go_fault();
        phase      = AT_FAULT;
        error_flag = 1'b1;
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic void take_char(logic [7:0] ch, logic last);
        logic        ws;
        logic        dig;
        logic        closed;
        logic [19:0] clen;
        logic [9:0]  coff;
        int          sum;
        t_result     r;
        ws     = (ch == CH_SP) || (ch == CH_TAB);
        dig    = (ch >= CH_0) && (ch <= CH_9);
        closed = 1'b0;
        clen   = '0;
        coff   = '0;
        if (ch != CH_NONE) begin
            case (phase)
                AT_GAP: begin
                    if (!(ws || ch == CH_LF || ch == CH_CR)) begin
                        if (ch != CH_LT || seg_count >= MAX_SEGMENTS) begin
                            go_fault();
                        end else begin
                            phase        = AT_KIND;
                            tag_kind     = KIND_STATIC;
                            number_value = '0;
                            digit_seen   = 1'b0;
                            nibble_half  = 1'b0;
                            tag_bytes    = '0;
                        end
                    end
                end
                AT_KIND: begin
                    if (ch == CH_B) begin
                        tag_kind = KIND_STATIC;
                        phase    = AT_B_BLANK;
                    end else if (ch == CH_R) begin
                        phase = AT_R_SELECT;
                    end else if (ch == CH_T) begin
                        tag_kind = KIND_TIMESTAMP;
                        phase    = AT_SKIP;
                    end else if (ch == CH_C) begin
                        tag_kind = KIND_COUNTER;
                        phase    = AT_SKIP;
                    end else begin
                        go_fault();
                    end
                end
                AT_B_BLANK: begin
                    if (!ws) begin
                        if (ch == CH_0) phase = AT_B_X;
                        else go_fault();
                    end
                end
                AT_B_X: begin
                    if (ch == CH_LO_X || ch == CH_UP_X) phase = AT_B_HEX;
                    else go_fault();
                end
                AT_B_HEX: begin
                    if (ch == CH_GT) begin
                        if (!nibble_half && tag_bytes != 0) begin
                            closed = 1'b1;
                            clen   = 20'(tag_bytes);
                            coff   = 10'(bytes_used - tag_bytes);
                        end else begin
                            go_fault();
                        end
                    end else if (!is_hex(ch)) begin
                        go_fault();
                    end else if (!nibble_half) begin
                        nibble_half = 1'b1;
                    end else if (bytes_used >= STATIC_BYTES) begin
                        go_fault();
                    end else begin
                        bytes_used  = bytes_used + 11'd1;
                        tag_bytes   = tag_bytes + 11'd1;
                        nibble_half = 1'b0;
                    end
                end
                AT_R_SELECT: begin
                    if (ch == CH_C) begin
                        tag_kind = KIND_LETTERS;
                        phase    = AT_R_NUMBER;
                    end else if (ch == CH_D) begin
                        tag_kind = KIND_DIGITS;
                        phase    = AT_R_NUMBER;
                    end else if (ws) begin
                        tag_kind = KIND_RANDOM;
                        phase    = AT_R_NUMBER;
                    end else if (dig) begin
                        tag_kind     = KIND_RANDOM;
                        phase        = AT_R_NUMBER;
                        number_value = 20'(ch - CH_0);
                        digit_seen   = 1'b1;
                    end else begin
                        go_fault();
                    end
                end
                AT_R_NUMBER: begin
                    if (ws) begin
                        if (digit_seen) go_fault();
                    end else if (dig) begin
                        if (number_value > NUM_LIMIT) begin
                            go_fault();
                        end else begin
                            number_value = 20'(number_value * 20'd10 + 20'(ch - CH_0));
                            digit_seen   = 1'b1;
                        end
                    end else if (ch == CH_GT) begin
                        if (digit_seen && number_value != 0) begin
                            closed = 1'b1;
                            clen   = number_value;
                        end else begin
                            go_fault();
                        end
                    end else begin
                        go_fault();
                    end
                end
                AT_SKIP: begin
                    if (ch == CH_GT) begin
                        closed = 1'b1;
                        clen   = STAMP_BYTES;
                    end
                end
                default: ;
            endcase
        end

        if (closed) begin
            seg_count = seg_count + 5'd1;
            sum       = int'(size_sum) + int'(clen);
            if (sum > TOTAL_CAP) sum = TOTAL_CAP;
            size_sum  = 11'(sum);
            phase     = AT_GAP;
            r            = '0;
            r.seg_valid  = 1'b1;
            r.seg_kind   = tag_kind;
            r.seg_length = clen;
            r.seg_offset = (tag_kind == KIND_STATIC) ? coff : 10'd0;
            r.end_of_run = !last;
            awaited_words.push_back(r);
        end

        if (last) begin
            r               = '0;
            r.done_res      = 1'b1;
            r.status        = error_flag || phase != AT_GAP || seg_count == 0 ||
                              size_sum > max_total;
            r.segment_count = seg_count;
            r.total_size    = size_sum;
            r.end_of_run    = 1'b1;
            awaited_words.push_back(r);
            clear_template();
        end
    endfunction

    function automatic string show(t_result r);
        return $sformatf({"seg=%0d kind=%0d len=%0d off=%0d done=%0d ",
                          "status=%0d count=%0d total=%0d end=%0d"},
                         r.seg_valid, r.seg_kind, r.seg_length, r.seg_offset, r.done_res,
                         r.status, r.segment_count, r.total_size, r.end_of_run);
    endfunction

    function automatic void check_word();
        t_result got;
        t_result want;
        got.seg_valid     = i_out.seg_valid;
        got.seg_kind      = t_kind'(i_out.seg_kind);
        got.seg_length    = i_out.seg_length;
        got.seg_offset    = i_out.seg_offset;
        got.done_res      = i_out.done_res;
        got.status        = i_out.status;
        got.segment_count = i_out.segment_count;
        got.total_size    = i_out.total_size;
        got.end_of_run    = i_out.end_of_run;
        if (awaited_words.size() == 0) begin
            fails++;
            if (fails <= SHOWN_FAILS)
                $display("%0t: result word with nothing awaited: %s", $realtime, show(got));
        end else begin
            want = awaited_words.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= SHOWN_FAILS) begin
                    $display("%0t: result word mismatch", $realtime);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_template();
            max_total = 11'(MAX_TOTAL_RST);
            awaited_words.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) max_total = i_cfg.max_total;
            if (i_in.valid && i_in.ready) take_char(i_in.ch, i_in.last);
            if (i_out.valid && i_out.ready) check_word();
        end
        o_pending    <= awaited_words.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the parser testbench: clock, reset, template stimulus, limit writes and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpp_pkg::*;

    localparam logic [7:0] CH_NONE      = 8'h00;
    localparam logic [7:0] CH_GT        = ">";
    localparam int         RANDOM_CHARS = 600;
    localparam int         IDLE_PCT     = 34;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic rx_ready = 1'b0;
    logic steady = 1'b0;
    int   fail_count;
    int   pending;
    int   sent_chars = 0;
    int   phase_no;

    logic [7:0] tmpl[$];
    string      hex_lower = "0123456789abcdef";
    string      hex_upper = "0123456789ABCDEF";
    string      blanks = " \t\r\n";

    string directed_text[$] = {
        "<b 0x00FF>",
        "<b\t 0XaBcDeF09><r 7><rc 12><rd 3>",
        " \t\r\n<t time stamp>\n<c>\r\n",
        "<rc5><rd\t 42>",
        "<r 1000009>",
        "<r1000010>",
        "<r 0>",
        "<r >",
        "<r 5 >",
        "<rz 5>",
        "<b 0x123>",
        "<b 0x>",
        "<b 1x00>",
        "<b 0y00>",
        "<b 0xg0>",
        "<x>",
        "a<t>",
        "<r 5><t",
        "   ",
        "<t>>"
    };

    tpp_in_if  in_ch();
    tpp_cfg_if cfg_ch();
    tpp_out_if out_ch();

    assign out_ch.ready = rx_ready;

    packet_template_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    template_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rx_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void add_text(string s);
        int k;
        for (k = 0; k < s.len(); k++) tmpl.push_back(s[k]);
    endfunction

    function automatic void add_blanks(int count, int kinds);
        int k;
        for (k = 0; k < count; k++) tmpl.push_back(blanks[$urandom_range(0, kinds - 1)]);
    endfunction

    function automatic void add_hex_bytes(int count);
        int k;
        int v;
        for (k = 0; k < 2 * count; k++) begin
            v = $urandom_range(0, 15);
            tmpl.push_back($urandom_range(0, 1) ? hex_lower[v] : hex_upper[v]);
        end
    endfunction

    // Mostly small sizes; now and then zero, a value near the digit limit, or a value past it.
    function automatic int pick_size();
        case ($urandom_range(0, 24))
            0: return 0;
            1: return $urandom_range(100000, 1000009);
            2: return $urandom_range(1000010, 99999999);
            default: return $urandom_range(1, 150);
        endcase
    endfunction

    function automatic void build_random_template();
        int         n_seg;
        int         s;
        int         k;
        int         pos;
        logic [7:0] c;
        tmpl.delete();
        if ($urandom_range(0, 29) == 0) n_seg = 0;
        else if ($urandom_range(0, 19) == 0) n_seg = $urandom_range(15, 18);
        else n_seg = $urandom_range(1, 5);
        for (s = 0; s < n_seg; s++) begin
            add_blanks($urandom_range(0, 2), 4);
            case ($urandom_range(0, 5))
                0: begin
                    add_text("<b");
                    add_blanks($urandom_range(0, 2), 2);
                    add_text($urandom_range(0, 1) ? "0x" : "0X");
                    add_hex_bytes(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6));
                end
                1: begin
                    add_text("<r");
                    add_blanks($urandom_range(0, 1), 2);
                    add_text($sformatf("%0d", pick_size()));
                end
                2, 3: begin
                    add_text($urandom_range(0, 1) ? "<rc" : "<rd");
                    add_blanks($urandom_range(0, 2), 2);
                    add_text($sformatf("%0d", pick_size()));
                end
                default: begin
                    add_text($urandom_range(0, 1) ? "<t" : "<c");
                    for (k = $urandom_range(0, 4); k > 0; k--) begin
                        do c = 8'($urandom_range(1, 255)); while (c == CH_GT);
                        tmpl.push_back(c);
                    end
                end
            endcase
            add_text(">");
        end
        add_blanks($urandom_range(0, 2), 4);
        // A minority of templates are damaged: a stray byte or a cut-off tail.
        if (tmpl.size() > 0 && $urandom_range(0, 6) == 0) begin
            pos = $urandom_range(0, tmpl.size() - 1);
            if ($urandom_range(0, 1)) tmpl[pos] = 8'($urandom_range(1, 255));
            else while (tmpl.size() > pos) void'(tmpl.pop_back());
        end
        if ($urandom_range(0, 3) == 0) tmpl.insert($urandom_range(0, tmpl.size()), CH_NONE);
        if (tmpl.size() == 0 || $urandom_range(0, 9) == 0) tmpl.push_back(CH_NONE);
    endfunction

    function automatic void build_tag_run(int count);
        int k;
        tmpl.delete();
        for (k = 0; k < count; k++) add_text((k % 2) ? "<t>" : "<c>");
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        in_ch.last  <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (c != CH_NONE) sent_chars++;
    endtask

    task automatic send_template();
        int k;
        for (k = 0; k < tmpl.size(); k++) send_char(tmpl[k], k == tmpl.size() - 1);
    endtask

    task automatic send_text(string s);
        tmpl.delete();
        add_text(s);
        send_template();
    endtask

    // Holds the sender back until every awaited word has come out.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [10:0] v);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.max_total <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.ch         = CH_NONE;
        in_ch.last       = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.max_total = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed templates run with the limit left at its reset value.
        foreach (directed_text[d]) send_text(directed_text[d]);
        tmpl.delete();
        add_text("<t");
        tmpl.push_back(CH_NONE);
        add_text(">");
        send_template();
        tmpl.delete();
        tmpl.push_back(CH_NONE);
        send_template();
        build_tag_run(MAX_SEGMENTS);
        send_template();
        build_tag_run(MAX_SEGMENTS + 1);
        send_template();
        // Fill the byte store to its last entry, then overflow it.
        tmpl.delete();
        add_text("<b 0x");
        add_hex_bytes(STATIC_BYTES - 1);
        add_text("><b 0x5A><b 0x11>");
        send_template();

        wait_idle();
        write_limit(11'(TOTAL_CAP));
        send_text("<r 1000009>");
        send_text("<r 2047>");
        send_text("<r 2048>");

        // The store test above already sends most of the characters, so the random
        // part is kept short, but it always reaches the stretch without idling.
        sent_chars = 0;
        phase_no   = 0;
        while (sent_chars < RANDOM_CHARS || phase_no < 3) begin
            wait_idle();
            steady <= (phase_no == 2);
            if (phase_no == 0) write_limit(11'd1);
            else if (phase_no == 1) write_limit(11'(MAX_TOTAL_RST));
            else write_limit(11'($urandom_range(1, TOTAL_CAP)));
            repeat (8) begin
                build_random_template();
                send_template();
            end
            phase_no++;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
